[rtl/core/shbr_pkg.sv]
// Package for the stuffed-bit header reader: constants, codes, control structs, marker table.
`timescale 1ns / 1ps
package shbr_pkg;

    // Byte FIFO; depth is a power of two so pointers wrap naturally.
    localparam int FIFO_DEPTH = 16;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    // Bit reads: width of the bits field, longest read, request counter width.
    localparam int BITS_W     = 32;
    localparam int MAX_BITS   = 32;
    localparam int NCNT_W     = 6;

    // Byte offsets within one transaction: at most six bytes (SOP) are touched.
    localparam int DROP_W     = 3;
    localparam int SOP_LEN    = 6;
    localparam int SOP_CHK    = 4;
    localparam int EPH_LEN    = 2;
    localparam int EPH_CHK    = 2;

    localparam logic [7:0] STUFF_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        CMD_PUSH        = 3'd0,
        CMD_START       = 3'd1,
        CMD_READ        = 3'd2,
        CMD_ALIGN       = 3'd3,
        CMD_SOP         = 3'd4,
        CMD_EPH         = 3'd5,
        CMD_RETRY_EPH   = 3'd6,
        CMD_RETRY_ALIGN = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STARVED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD_FIRST,
        S_RD_STEP,
        S_RD_FETCH,
        S_MK_CHK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic              push;
        logic              rd;
        logic [ADDR_W-1:0] rd_off;
        logic              drop;
        logic [DROP_W-1:0] drop_num;
    } fifo_ctl_t;

    typedef struct packed {
        logic begin_rd;   // copy committed state into work copy, clear accumulator
        logic load;       // load fetched byte into work copy
        logic shift;      // move one bit into the accumulator
        logic commit;     // work copy becomes committed state
        logic first;      // header start: committed state from first byte
        logic clear;      // byte align: drop partial byte
    } bitx_ctl_t;

    typedef struct packed {
        logic work_empty;
        logic nb_is7;
    } bitx_sts_t;

    // Expected marker bytes: SOP is FF 91 00 04, EPH is FF 92.
    function automatic logic [7:0] marker_byte(input logic is_eph, input logic [DROP_W-1:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                3'd0:    b = 8'hFF;
                3'd1:    b = is_eph ? 8'h92 : 8'h91;
                3'd2:    b = 8'h00;
                3'd3:    b = 8'h04;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

[rtl/core/shbr_fifo.sv]
// Byte FIFO with offset peek (registered read) and multi-byte drop.
`timescale 1ns / 1ps
module shbr_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  shbr_pkg::fifo_ctl_t       ctl,
    input  logic [7:0]                wr_data,
    output logic [7:0]                rd_data,
    output logic [shbr_pkg::CNT_W-1:0] count
);
    import shbr_pkg::*;

    logic [7:0]        mem [FIFO_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (ctl.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctl.drop)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(ctl.drop_num);
            cnt_next    = cnt_reg - CNT_W'(ctl.drop_num);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[rd_idx_reg + cnt_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_idx_reg + ctl.rd_off];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = cnt_reg;

endmodule

[rtl/core/shbr_bitx.sv]
// Bit-serial extractor: byte shift register, unstuffing, accumulator, commit/rollback.
`timescale 1ns / 1ps
module shbr_bitx (
    input  logic                        clk,
    input  logic                        rst_n,
    input  shbr_pkg::bitx_ctl_t         ctl,
    input  logic [7:0]                  byte_in,
    output shbr_pkg::bitx_sts_t         sts,
    output logic [shbr_pkg::BITS_W-1:0] acc
);
    import shbr_pkg::*;

    // Committed state; sh holds the unread bits left-aligned.
    logic [7:0]        sh_reg, sh_next;
    logic [3:0]        bl_reg, bl_next;
    logic [3:0]        nb_reg, nb_next;
    // Work copy used during a read, discarded when starved.
    logic [7:0]        w_sh_reg, w_sh_next;
    logic [3:0]        w_bl_reg, w_bl_next;
    logic [3:0]        w_nb_reg, w_nb_next;
    logic [BITS_W-1:0] acc_reg, acc_next;
    logic [3:0]        nbits;

    assign nbits = (w_nb_reg == 4'd0) ? 4'd8 : w_nb_reg;

    always_comb
    begin
        sh_next   = sh_reg;
        bl_next   = bl_reg;
        nb_next   = nb_reg;
        w_sh_next = w_sh_reg;
        w_bl_next = w_bl_reg;
        w_nb_next = w_nb_reg;
        acc_next  = acc_reg;
        if (ctl.begin_rd)
        begin
            w_sh_next = sh_reg;
            w_bl_next = bl_reg;
            w_nb_next = nb_reg;
            acc_next  = '0;
        end
        if (ctl.load)
        begin
            // after a stuffed byte only the low seven bits carry data
            w_sh_next = (nbits == 4'd7) ? {byte_in[6:0], 1'b0} : byte_in;
            w_bl_next = nbits;
            w_nb_next = (nbits == 4'd8 && byte_in == STUFF_BYTE) ? 4'd7 : 4'd8;
        end
        if (ctl.shift)
        begin
            acc_next  = {acc_reg[BITS_W-2:0], w_sh_reg[7]};
            w_sh_next = {w_sh_reg[6:0], 1'b0};
            w_bl_next = w_bl_reg - 4'd1;
        end
        if (ctl.commit)
        begin
            sh_next = w_sh_reg;
            bl_next = w_bl_reg;
            nb_next = w_nb_reg;
        end
        if (ctl.first)
        begin
            sh_next = byte_in;
            bl_next = 4'd8;
            nb_next = (byte_in == STUFF_BYTE) ? 4'd7 : 4'd8;
        end
        if (ctl.clear)
        begin
            sh_next = '0;
            bl_next = '0;
            nb_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg <= '0;
            bl_reg <= '0;
            nb_reg <= '0;
        end
        else
        begin
            sh_reg <= sh_next;
            bl_reg <= bl_next;
            nb_reg <= nb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_sh_reg <= w_sh_next;
        w_bl_reg <= w_bl_next;
        w_nb_reg <= w_nb_next;
        acc_reg  <= acc_next;
    end

    assign sts.work_empty = (w_bl_reg == 4'd0);
    assign sts.nb_is7     = (nb_reg == 4'd7);
    assign acc            = acc_reg;

endmodule

[rtl/core/stuffed_bit_header_reader_top.sv]
// Top level of the stuffed-bit header reader: command sequencer, result register, checks.
`timescale 1ns / 1ps
// Steps from accept: every command goes through dispatch, then finish; start with a byte load
// adds the first-byte load (an owed align skip is taken in dispatch before it); SOP and EPH
// skips add the marker check, one byte peeked per cycle. A bit read shifts one bit per cycle,
// except that each byte fetched costs a FIFO read and a load step before shifting resumes.
// One transaction at a time: the next accept comes in idle, after the result is registered.
// Reset (rst_n, async, active low) empties the FIFO and clears pending flags and bit state.
module stuffed_bit_header_reader_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [2:0]                  cmd,
    input  logic [7:0]                  data_byte,
    input  logic [5:0]                  bit_count,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [shbr_pkg::BITS_W-1:0] bits,
    output logic [1:0]                  status,
    output logic                        marker_skipped
);
    import shbr_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [7:0]         data_reg, data_next;
    logic [NCNT_W-1:0]  k_reg, k_next;          // bits still to read
    logic [DROP_W-1:0]  used_reg, used_next;    // bytes fetched / peeked so far
    logic               match_reg, match_next;
    logic               align_pend_reg, align_pend_next;
    logic               eph_pend_reg, eph_pend_next;
    status_t            res_status_reg, res_status_next;
    logic               res_marker_reg, res_marker_next;
    logic               res_sel_reg, res_sel_next; // bits come from the accumulator

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [BITS_W-1:0]  out_bits_reg, out_bits_next;
    status_t            out_status_reg, out_status_next;
    logic               out_marker_reg, out_marker_next;

    fifo_ctl_t          fctl;
    logic [7:0]         rd_data;
    logic [CNT_W-1:0]   cnt;
    bitx_ctl_t          bctl;
    bitx_sts_t          bsts;
    logic [BITS_W-1:0]  acc;

    logic               accept;
    logic               out_free;
    logic               is_eph;
    logic [DROP_W-1:0]  mk_last;
    logic               mk_match;
    logic [NCNT_W-1:0]  n_sat;

    shbr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fctl),
        .wr_data (data_reg),
        .rd_data (rd_data),
        .count   (cnt)
    );

    shbr_bitx u_bitx (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bctl),
        .byte_in (rd_data),
        .sts     (bsts),
        .acc     (acc)
    );

    assign accept   = item_valid && item_ready;
    assign out_free = !out_valid_reg || result_ready;
    assign is_eph   = (cmd_reg != CMD_SOP);
    assign mk_last  = is_eph ? DROP_W'(EPH_CHK) : DROP_W'(SOP_CHK);
    assign mk_match = match_reg && (rd_data == marker_byte(is_eph, used_reg - DROP_W'(1)));
    assign n_sat    = (bit_count > NCNT_W'(MAX_BITS)) ? NCNT_W'(MAX_BITS) : bit_count;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        if (cnt == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (!align_pend_reg)
                        begin
                            state_next = S_LOAD_FIRST;
                        end
                        // pending align: skip one byte and look again
                    end
                    CMD_READ:
                    begin
                        state_next = S_RD_STEP;
                    end
                    CMD_SOP:
                    begin
                        state_next = (cnt < CNT_W'(SOP_LEN)) ? S_FINISH : S_MK_CHK;
                    end
                    CMD_EPH, CMD_RETRY_EPH:
                    begin
                        if ((cmd_reg == CMD_RETRY_EPH && !eph_pend_reg)
                            || cnt < CNT_W'(EPH_LEN))
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_MK_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_LOAD_FIRST:
            begin
                state_next = S_FINISH;
            end
            S_RD_STEP:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (bsts.work_empty)
                begin
                    state_next = (CNT_W'(used_reg) >= cnt) ? S_FINISH : S_RD_FETCH;
                end
            end
            S_RD_FETCH:
            begin
                state_next = S_RD_STEP;
            end
            S_MK_CHK:
            begin
                if (used_reg == mk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        item_ready      = 1'b0;
        fctl            = '0;
        bctl            = '0;
        cmd_next        = cmd_reg;
        data_next       = data_reg;
        k_next          = k_reg;
        used_next       = used_reg;
        match_next      = match_reg;
        align_pend_next = align_pend_reg;
        eph_pend_next   = eph_pend_reg;
        res_status_next = res_status_reg;
        res_marker_next = res_marker_reg;
        res_sel_next    = res_sel_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_bits_next   = out_bits_reg;
        out_status_next = out_status_reg;
        out_marker_next = out_marker_reg;

        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    cmd_next        = cmd_t'(cmd);
                    data_next       = data_byte;
                    k_next          = n_sat;
                    res_status_next = ST_OK;
                    res_marker_next = 1'b0;
                    res_sel_next    = 1'b0;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (cnt == CNT_W'(FIFO_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            fctl.push = 1'b1;
                        end
                    end
                    CMD_START:
                    begin
                        if (cnt == '0)
                        begin
                            res_status_next = ST_STARVED;
                        end
                        else if (align_pend_reg)
                        begin
                            fctl.drop       = 1'b1;
                            fctl.drop_num   = DROP_W'(1);
                            align_pend_next = 1'b0;
                        end
                        else
                        begin
                            fctl.rd     = 1'b1;
                            fctl.rd_off = '0;
                        end
                    end
                    CMD_READ:
                    begin
                        bctl.begin_rd = 1'b1;
                        used_next     = '0;
                    end
                    CMD_ALIGN:
                    begin
                        align_pend_next = 1'b0;
                        bctl.clear      = 1'b1;
                        if (bsts.nb_is7)
                        begin
                            // skip the byte that follows a stuffed 0xFF
                            if (cnt != '0)
                            begin
                                fctl.drop     = 1'b1;
                                fctl.drop_num = DROP_W'(1);
                            end
                            else
                            begin
                                align_pend_next = 1'b1;
                                res_status_next = ST_STARVED;
                            end
                        end
                    end
                    CMD_SOP:
                    begin
                        if (cnt < CNT_W'(SOP_LEN))
                        begin
                            res_status_next = ST_STARVED;
                        end
                        else
                        begin
                            fctl.rd    = 1'b1;
                            fctl.rd_off = '0;
                            used_next  = DROP_W'(1);
                            match_next = 1'b1;
                        end
                    end
                    CMD_EPH, CMD_RETRY_EPH:
                    begin
                        if (cmd_reg == CMD_RETRY_EPH && !eph_pend_reg)
                        begin
                            res_status_next = ST_OK;
                        end
                        else if (cnt < CNT_W'(EPH_LEN))
                        begin
                            eph_pend_next   = 1'b1;
                            res_status_next = ST_STARVED;
                        end
                        else
                        begin
                            eph_pend_next = 1'b0;
                            fctl.rd       = 1'b1;
                            fctl.rd_off   = '0;
                            used_next     = DROP_W'(1);
                            match_next    = 1'b1;
                        end
                    end
                    CMD_RETRY_ALIGN:
                    begin
                        if (align_pend_reg)
                        begin
                            if (cnt == '0)
                            begin
                                res_status_next = ST_STARVED;
                            end
                            else
                            begin
                                fctl.drop       = 1'b1;
                                fctl.drop_num   = DROP_W'(1);
                                align_pend_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_LOAD_FIRST:
            begin
                bctl.first    = 1'b1;
                fctl.drop     = 1'b1;
                fctl.drop_num = DROP_W'(1);
            end
            S_RD_STEP:
            begin
                if (k_reg == '0)
                begin
                    bctl.commit   = 1'b1;
                    fctl.drop     = (used_reg != '0);
                    fctl.drop_num = used_reg;
                    res_sel_next  = 1'b1;
                end
                else if (bsts.work_empty)
                begin
                    if (CNT_W'(used_reg) >= cnt)
                    begin
                        // starved: work copy is discarded, FIFO untouched
                        res_status_next = ST_STARVED;
                    end
                    else
                    begin
                        fctl.rd     = 1'b1;
                        fctl.rd_off = ADDR_W'(used_reg);
                        used_next   = used_reg + DROP_W'(1);
                    end
                end
                else
                begin
                    bctl.shift = 1'b1;
                    k_next     = k_reg - NCNT_W'(1);
                end
            end
            S_RD_FETCH:
            begin
                bctl.load = 1'b1;
            end
            S_MK_CHK:
            begin
                if (used_reg == mk_last)
                begin
                    if (mk_match)
                    begin
                        fctl.drop       = 1'b1;
                        fctl.drop_num   = is_eph ? DROP_W'(EPH_LEN) : DROP_W'(SOP_LEN);
                        res_marker_next = 1'b1;
                    end
                end
                else
                begin
                    fctl.rd     = 1'b1;
                    fctl.rd_off = ADDR_W'(used_reg);
                    used_next   = used_reg + DROP_W'(1);
                    match_next  = mk_match;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bits_next   = res_sel_reg ? acc : '0;
                    out_status_next = res_status_reg;
                    out_marker_next = res_marker_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !result_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            align_pend_reg <= 1'b0;
            eph_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            align_pend_reg <= align_pend_next;
            eph_pend_reg   <= eph_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        data_reg       <= data_next;
        k_reg          <= k_next;
        used_reg       <= used_next;
        match_reg      <= match_next;
        res_status_reg <= res_status_next;
        res_marker_reg <= res_marker_next;
        res_sel_reg    <= res_sel_next;
        out_bits_reg   <= out_bits_next;
        out_status_reg <= out_status_next;
        out_marker_reg <= out_marker_next;
    end

    assign result_valid   = out_valid_reg;
    assign bits           = out_bits_reg;
    assign status         = out_status_reg;
    assign marker_skipped = out_marker_reg;

    // ---------------- checks ----------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(FIFO_DEPTH))
        else $error("FIFO fill count above depth");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(used_reg) <= cnt || state_reg == S_IDLE || state_reg == S_DISPATCH
        || state_reg == S_FINISH || state_reg == S_LOAD_FIRST)
        else $error("byte cursor ran past FIFO contents");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FINISH))
        else $error("result presented outside finish step");

    a_marker_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && marker_skipped |-> status == ST_OK)
        else $error("marker skip reported with bad status");

endmodule

[bench/stuffed_bit_header_reader_top_tb.sv]
// Self-checking testbench for the stuffed-bit header reader: directed and random commands.
`timescale 1ns / 1ps
module stuffed_bit_header_reader_top_tb;
    import shbr_pkg::*;

    // Marker bytes that follow the 0xFF lead byte, and the SOP segment length.
    localparam logic [7:0] SOP_CODE    = 8'h91;
    localparam logic [7:0] EPH_CODE    = 8'h92;
    localparam logic [7:0] SOP_LSEG_HI = 8'h00;
    localparam logic [7:0] SOP_LSEG_LO = 8'h04;

    localparam int ITEM_TARGET = 1850;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction on either side
    localparam int TAIL_CYCLES = 60;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [31:0] bits;
        status_t     status;
        logic        marker;
    } header_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [2:0]  cmd = CMD_PUSH;
    logic [7:0]  data_byte = 8'h00;
    logic [5:0]  bit_count = 6'd0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] bits;
    logic [1:0]  status;
    logic        marker_skipped;

    // Predicted reader state, updated as each command is accepted.
    logic [7:0] fifo_bytes [FIFO_DEPTH];
    int         head_ptr = 0;
    int         fill_level = 0;
    logic [7:0] cur_byte = 8'h00;
    int         cur_bits_left = 0;
    int         next_width = 0;
    bit         align_owed = 1'b0;
    bit         eph_owed = 1'b0;

    header_result_t expected_results [$];
    header_result_t want;
    int  items_sent = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  hold_cycles = 0;
    int  stall_left = 0;
    bit  sender_idle_on = 1'b1;
    bit  receiver_idle_on = 1'b1;

    stuffed_bit_header_reader_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .bits           (bits),
        .status         (status),
        .marker_skipped (marker_skipped)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] byte_at(int k);
        return fifo_bytes[(head_ptr + k) % FIFO_DEPTH];
    endfunction

    function automatic void discard(int k);
        if (k > fill_level)
            k = fill_level;
        head_ptr = (head_ptr + k) % FIFO_DEPTH;
        fill_level -= k;
    endfunction

    function automatic header_result_t compute_header_result(cmd_t op, logic [7:0] din,
                                                             logic [5:0] nreq);
        header_result_t r;
        int n, i, used, bl, nb, width;
        logic [7:0] cb;
        logic [31:0] acc;
        bit starved;
        r.bits = '0;
        r.status = ST_OK;
        r.marker = 1'b0;
        case (op)
            CMD_PUSH:
            begin
                if (fill_level >= FIFO_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    fifo_bytes[(head_ptr + fill_level) % FIFO_DEPTH] = din;
                    fill_level++;
                end
            end
            CMD_START:
            begin
                // an owed align skip comes first; with nothing to skip, nothing moves
                if (align_owed && fill_level == 0)
                    r.status = ST_STARVED;
                else
                begin
                    if (align_owed)
                    begin
                        discard(1);
                        align_owed = 1'b0;
                    end
                    if (fill_level == 0)
                        r.status = ST_STARVED;
                    else
                    begin
                        cur_byte = byte_at(0);
                        discard(1);
                        cur_bits_left = 8;
                        next_width = (cur_byte == STUFF_BYTE) ? 7 : 8;
                    end
                end
            end
            CMD_READ:
            begin
                n = (nreq > MAX_BITS) ? MAX_BITS : nreq;
                cb = cur_byte;
                bl = cur_bits_left;
                nb = next_width;
                used = 0;
                acc = '0;
                starved = 1'b0;
                for (i = 0; i < n && !starved; i++)
                begin
                    if (bl == 0)
                    begin
                        // width 0 means no header start since align: take a whole byte
                        width = (nb == 0) ? 8 : nb;
                        if (used >= fill_level)
                            starved = 1'b1;
                        else
                        begin
                            cb = byte_at(used);
                            used++;
                            bl = width;
                            nb = (width == 8 && cb == STUFF_BYTE) ? 7 : 8;
                        end
                    end
                    if (!starved)
                    begin
                        bl--;
                        acc = {acc[30:0], cb[bl]};
                    end
                end
                if (starved)
                    r.status = ST_STARVED;
                else
                begin
                    r.bits = acc;
                    cur_byte = cb;
                    cur_bits_left = bl;
                    next_width = nb;
                    discard(used);
                end
            end
            CMD_ALIGN:
            begin
                align_owed = 1'b0;
                if (next_width == 7)
                begin
                    if (fill_level > 0)
                        discard(1);
                    else
                    begin
                        align_owed = 1'b1;
                        r.status = ST_STARVED;
                    end
                end
                cur_byte = 8'h00;
                cur_bits_left = 0;
                next_width = 0;
            end
            CMD_SOP:
            begin
                if (fill_level < SOP_LEN)
                    r.status = ST_STARVED;
                else if (byte_at(0) == STUFF_BYTE && byte_at(1) == SOP_CODE &&
                         byte_at(2) == SOP_LSEG_HI && byte_at(3) == SOP_LSEG_LO)
                begin
                    discard(SOP_LEN);
                    r.marker = 1'b1;
                end
            end
            CMD_EPH, CMD_RETRY_EPH:
            begin
                if (op == CMD_EPH || eph_owed)
                begin
                    if (fill_level < EPH_LEN)
                    begin
                        eph_owed = 1'b1;
                        r.status = ST_STARVED;
                    end
                    else
                    begin
                        eph_owed = 1'b0;
                        if (byte_at(0) == STUFF_BYTE && byte_at(1) == EPH_CODE)
                        begin
                            discard(EPH_LEN);
                            r.marker = 1'b1;
                        end
                    end
                end
            end
            CMD_RETRY_ALIGN:
            begin
                if (align_owed)
                begin
                    if (fill_level == 0)
                        r.status = ST_STARVED;
                    else
                    begin
                        discard(1);
                        align_owed = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- pacing

    // Mostly no pause, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 3)
            return STUFF_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] pick_length();
        if ($urandom_range(0, 9) < 7)
            return 6'($urandom_range(1, 8));
        return 6'($urandom_range(9, MAX_BITS));
    endfunction

    // ---------------------------------------------------------------- driver

    // Called at a rising edge. Valid stays high across back-to-back transactions.
    task automatic send_command(cmd_t op, logic [7:0] din = 8'h00, logic [5:0] nreq = 6'd0);
        int gap;
        item_valid <= 1'b1;
        cmd        <= op;
        data_byte  <= din;
        bit_count  <= nreq;
        // inputs and outputs only move at rising edges, so the falling edge shows
        // what the next rising edge will see
        do
            @(negedge clk);
        while (item_ready !== 1'b1);
        @(posedge clk);
        expected_results.push_back(compute_header_result(op, din, nreq));
        items_sent++;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_byte(logic [7:0] b);
        send_command(CMD_PUSH, b);
    endtask

    task automatic read_bits(logic [5:0] n);
        send_command(CMD_READ, 8'h00, n);
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- receiver

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (receiver_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid === 1'b1 && result_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none pending", bits, 32'h0);
                else
                begin
                    want = expected_results.pop_front();
                    if (bits !== want.bits)
                        report_mismatch("bits", bits, want.bits);
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (marker_skipped !== want.marker)
                        report_mismatch("marker_skipped", 32'(marker_skipped),
                                        32'(want.marker));
                end
            end
        end
    end

    // No transaction on either side for too long ends the run.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Empty FIFO: starved read and start, EPH kept pending and finished by retries.
    task automatic test_empty_fifo();
        read_bits(6'd5);
        send_command(CMD_START);
        send_command(CMD_EPH);
        push_byte(STUFF_BYTE);
        send_command(CMD_RETRY_EPH);     // still one byte short
        push_byte(EPH_CODE);
        send_command(CMD_RETRY_EPH);     // marker consumed now
        send_command(CMD_RETRY_EPH);     // nothing pending
        send_command(CMD_RETRY_ALIGN);   // nothing pending
    endtask

    // Align after a 0xFF with no stuffed byte present, then start with the skip owed.
    task automatic test_align_pending();
        push_byte(STUFF_BYTE);
        send_command(CMD_START);
        send_command(CMD_ALIGN);
        send_command(CMD_RETRY_ALIGN);
        send_command(CMD_START);         // owed skip, FIFO empty
        push_byte(8'h55);
        push_byte(STUFF_BYTE);
        send_command(CMD_START);         // skips 0x55, loads 0xFF
        send_command(CMD_SOP);           // too few bytes
    endtask

    // Fill the FIFO, overflow it, then skip markers and read across stuffed bytes.
    task automatic test_full_fifo();
        logic [7:0] fill_seq [FIFO_DEPTH];
        int k;
        fill_seq = '{STUFF_BYTE, SOP_CODE, SOP_LSEG_HI, SOP_LSEG_LO, 8'h12, 8'h34,
                     STUFF_BYTE, 8'h7F, STUFF_BYTE, 8'h80, 8'h00, STUFF_BYTE,
                     EPH_CODE, 8'hA5, 8'h5A, 8'hC3};
        for (k = 0; k < FIFO_DEPTH; k++)
            push_byte(fill_seq[k]);
        push_byte(8'h00);                // dropped: FIFO full
        send_command(CMD_SOP);
        send_command(CMD_START);
        send_command(CMD_SOP);           // enough bytes but no marker
        read_bits(6'd63);                // saturates to the longest read
        read_bits(6'd0);
        send_command(CMD_EPH);
        send_command(CMD_EPH);           // no marker at the head
        send_command(CMD_ALIGN);
        read_bits(6'd1);                 // no start since align: whole byte loaded
        drain_results();
    endtask

    // Packet-shaped sequences: optional SOP, header bytes, start, reads, align, EPH.
    task automatic test_random_packets(int upto);
        logic [7:0] sop_seq [SOP_LEN];
        int k, hdr_len, nreads, flavor;
        while (items_sent < upto)
        begin
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            // byte-align and consume leftovers so the next marker sits at the head
            send_command(CMD_ALIGN);
            while (fill_level > 0)
                read_bits(6'(cur_bits_left + 1));
            if ($urandom_range(0, 9) < 7)
            begin
                sop_seq = '{STUFF_BYTE, SOP_CODE, SOP_LSEG_HI, SOP_LSEG_LO,
                            pick_byte(), pick_byte()};
                if ($urandom_range(0, 7) == 0)
                    sop_seq[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                for (k = 0; k < SOP_LEN; k++)
                    push_byte(sop_seq[k]);
            end
            hdr_len = $urandom_range(1, 6);
            for (k = 0; k < hdr_len; k++)
                push_byte(pick_byte());
            if ($urandom_range(0, 9) < 8)
                send_command(CMD_SOP);
            send_command(CMD_START);
            nreads = $urandom_range(1, 5);
            for (k = 0; k < nreads; k++)
                read_bits(pick_length());
            if ($urandom_range(0, 7) != 0)
                send_command(CMD_ALIGN);
            flavor = $urandom_range(0, 3);
            case (flavor)
                0:
                begin
                    push_byte(STUFF_BYTE);
                    push_byte(EPH_CODE);
                    send_command(CMD_EPH);
                end
                1:
                begin
                    send_command(CMD_EPH);
                    push_byte(STUFF_BYTE);
                    push_byte(EPH_CODE);
                    send_command(CMD_RETRY_EPH);
                end
                2:
                begin
                    push_byte(pick_byte());
                    push_byte(pick_byte());
                    send_command(CMD_EPH);
                end
                default:
                begin
                end
            endcase
            if (align_owed && $urandom_range(0, 1) == 1)
            begin
                push_byte(pick_byte());
                send_command(CMD_RETRY_ALIGN);
            end
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering: the block backs up.
    task automatic test_output_hold();
        int k;
        sender_idle_on = 1'b0;
        hold_cycles = HOLD_CYCLES;
        for (k = 0; k < 4; k++)
            push_byte(pick_byte());
        send_command(CMD_START);
        read_bits(pick_length());
        read_bits(pick_length());
        send_command(CMD_ALIGN);
        drain_results();
        sender_idle_on = 1'b1;
    endtask

    // Unshaped commands over every field value, including odd read lengths.
    task automatic test_random_noise(int upto);
        int r;
        cmd_t op;
        logic [7:0] din;
        logic [5:0] nreq;
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                sender_idle_on   = ($urandom_range(0, 3) != 0);
                receiver_idle_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 9);
            op = (r < 4) ? CMD_PUSH : cmd_t'($urandom_range(0, 7));
            r = $urandom_range(0, 9);
            din = (r == 0) ? SOP_CODE : (r == 1) ? EPH_CODE : pick_byte();
            nreq = ($urandom_range(0, 9) < 7) ? pick_length() : 6'($urandom_range(0, 63));
            send_command(op, din, nreq);
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_fifo();
        test_align_pending();
        test_full_fifo();
        test_random_packets(900);
        test_output_hold();
        test_random_packets(1400);
        test_random_noise(ITEM_TARGET);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
